### src/qwvs_pkg.sv
package qwvs_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = CROSS_W;
	localparam int EDGE_W = 18;
	localparam int SRC_W = 16;
	localparam int TEX_W = 48;
	localparam int Q_W = 32;
	localparam int TPROD_W = EDGE_W + Q_W + 1;
	localparam int NUM_CORNERS = 4;
	localparam int IDX_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ROT_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TOP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 3'd4;

	localparam logic [ROT_W-1:0] ROT_ROTATE = 2'd1;
	localparam logic [ROT_W-1:0] ROT_SWAP = 2'd2;

	localparam logic [IDX_W-1:0] CORNER_TL = 2'd0;
	localparam logic [IDX_W-1:0] CORNER_BL = 2'd1;
	localparam logic [IDX_W-1:0] CORNER_TR = 2'd2;
	localparam logic [IDX_W-1:0] CORNER_BR = 2'd3;

	typedef struct packed {
		logic [MAG_W-1:0] own;
		logic [MAG_W-1:0] opp;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [EDGE_W-1:0] eu;
		logic signed [EDGE_W-1:0] ev;
		logic bad;
	} lane_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [EDGE_W-1:0] eu;
		logic signed [EDGE_W-1:0] ev;
		logic bad;
	} side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [TEX_W-1:0] tex_u;
		logic signed [TEX_W-1:0] tex_v;
		logic [Q_W-1:0] tex_q;
	} vertex_t;

	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [CROSS_W:0] v);
		logic signed [CROSS_W:0] a;
		a = (v < 0) ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic [TEX_W-1:0] clamp_tex(input logic signed [TPROD_W-1:0] p);
		logic [TEX_W-1:0] r;
		if (&p[TPROD_W-1:TEX_W-1] || ~|p[TPROD_W-1:TEX_W-1]) begin
			r = p[TEX_W-1:0];
		end else if (p[TPROD_W-1]) begin
			r = {1'b1, {(TEX_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(TEX_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [TEX_W-1:0] degen_tex(input logic signed [EDGE_W-1:0] e);
		logic [TEX_W-1:0] r;
		if (e > 0) begin
			r = {1'b0, {(TEX_W-1){1'b1}}};
		end else if (e < 0) begin
			r = {1'b1, {(TEX_W-1){1'b0}}};
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

### src/qwvs_in_if.sv
interface qwvs_in_if;
	logic valid;
	logic ready;
	logic signed [qwvs_pkg::COORD_W-1:0] top_left_x;
	logic signed [qwvs_pkg::COORD_W-1:0] top_left_y;
	logic signed [qwvs_pkg::COORD_W-1:0] bottom_left_x;
	logic signed [qwvs_pkg::COORD_W-1:0] bottom_left_y;
	logic signed [qwvs_pkg::COORD_W-1:0] top_right_x;
	logic signed [qwvs_pkg::COORD_W-1:0] top_right_y;
	logic signed [qwvs_pkg::COORD_W-1:0] bottom_right_x;
	logic signed [qwvs_pkg::COORD_W-1:0] bottom_right_y;

	modport source (output valid, top_left_x, top_left_y, bottom_left_x, bottom_left_y,
		top_right_x, top_right_y, bottom_right_x, bottom_right_y, input ready);
	modport sink (input valid, top_left_x, top_left_y, bottom_left_x, bottom_left_y,
		top_right_x, top_right_y, bottom_right_x, bottom_right_y, output ready);
endinterface

### src/qwvs_out_if.sv
interface qwvs_out_if;
	logic valid;
	logic ready;
	logic signed [qwvs_pkg::COORD_W-1:0] vertex_x;
	logic signed [qwvs_pkg::COORD_W-1:0] vertex_y;
	logic signed [qwvs_pkg::TEX_W-1:0] tex_u;
	logic signed [qwvs_pkg::TEX_W-1:0] tex_v;
	logic [qwvs_pkg::Q_W-1:0] tex_q;
	logic [qwvs_pkg::IDX_W-1:0] vertex_index;
	logic last;
	logic degenerate;

	modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, tex_q, vertex_index,
		last, degenerate, input ready);
	modport sink (input valid, vertex_x, vertex_y, tex_u, tex_v, tex_q, vertex_index,
		last, degenerate, output ready);
endinterface

### src/qwvs_cfg_if.sv
interface qwvs_cfg_if;
	logic valid;
	logic ready;
	logic [qwvs_pkg::CFG_IDX_W-1:0] index;
	logic [qwvs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/qwvs_lane.sv
module qwvs_lane #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic adv,
	input qwvs_pkg::lane_in_t lin,
	output qwvs_pkg::vertex_t vout
);

	localparam int DEN_W = qwvs_pkg::MAG_W + 1;
	localparam int NUM_W = qwvs_pkg::MAG_W + FRAC_BITS + 2;
	localparam int STEPS = qwvs_pkg::Q_W;
	localparam int CMP_W = DEN_W + STEPS;

	logic [qwvs_pkg::MAG_W:0] sum_c;
	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;
	logic sat_c;

	logic [DEN_W-1:0] rem_s [STEPS+1];
	logic [DEN_W-1:0] den_s [STEPS+1];
	logic [STEPS-1:0] low_s [STEPS+1];
	logic [STEPS-1:0] quo_s [STEPS+1];
	logic sat_s [STEPS+1];
	qwvs_pkg::side_t side_s [STEPS+1];

	logic [qwvs_pkg::Q_W-1:0] q_fin;
	logic signed [qwvs_pkg::TPROD_W-1:0] pu;
	logic signed [qwvs_pkg::TPROD_W-1:0] pv;

	assign sum_c = {1'b0, lin.own} + {1'b0, lin.opp};
	assign num_c = NUM_W'({sum_c, {FRAC_BITS{1'b0}}}) + NUM_W'(lin.opp);
	assign den_c = {lin.opp, 1'b0};
	assign sat_c = CMP_W'(num_c) >= {den_c, {STEPS{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= DEN_W'(num_c[NUM_W-1:STEPS]);
			den_s[0] <= den_c;
			low_s[0] <= num_c[STEPS-1:0];
			quo_s[0] <= '0;
			sat_s[0] <= sat_c;
			side_s[0] <= '{x: lin.x, y: lin.y, eu: lin.eu, ev: lin.ev, bad: lin.bad};
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic ge;

		assign trial = {rem_s[k], low_s[k][STEPS-1]};
		assign diff = trial - {1'b0, den_s[k]};
		assign ge = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_s[k+1] <= den_s[k];
				low_s[k+1] <= {low_s[k][STEPS-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][STEPS-2:0], ge};
				sat_s[k+1] <= sat_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign q_fin = (side_s[STEPS].bad || sat_s[STEPS]) ? '1 : quo_s[STEPS];
	assign pu = side_s[STEPS].eu * $signed({1'b0, q_fin});
	assign pv = side_s[STEPS].ev * $signed({1'b0, q_fin});

	always_ff @(posedge clk) begin
		if (adv) begin
			vout.x <= side_s[STEPS].x;
			vout.y <= side_s[STEPS].y;
			vout.tex_q <= q_fin;
			vout.tex_u <= side_s[STEPS].bad ? qwvs_pkg::degen_tex(side_s[STEPS].eu)
				: qwvs_pkg::clamp_tex(pu);
			vout.tex_v <= side_s[STEPS].bad ? qwvs_pkg::degen_tex(side_s[STEPS].ev)
				: qwvs_pkg::clamp_tex(pv);
		end
	end

endmodule

### src/qwvs_merge.sv
module qwvs_merge (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input qwvs_pkg::vertex_t vin [qwvs_pkg::NUM_CORNERS],
	input logic in_degen,
	output logic can_load,
	qwvs_out_if.source vertices
);

	localparam logic [qwvs_pkg::IDX_W-1:0] LAST_IDX = qwvs_pkg::CORNER_BR;

	qwvs_pkg::vertex_t buf_q [qwvs_pkg::NUM_CORNERS];
	logic deg_q;
	logic full_q;
	logic [qwvs_pkg::IDX_W-1:0] idx_q;
	logic load;

	assign can_load = !full_q || (vertices.ready && idx_q == LAST_IDX);
	assign load = in_valid && can_load;

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= vin;
			deg_q <= in_degen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q <= qwvs_pkg::CORNER_TL;
		end else if (full_q && vertices.ready) begin
			if (idx_q == LAST_IDX) begin
				idx_q <= qwvs_pkg::CORNER_TL;
				full_q <= in_valid;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (!full_q) begin
			full_q <= in_valid;
		end
	end

	assign vertices.valid = full_q;
	assign vertices.vertex_x = buf_q[idx_q].x;
	assign vertices.vertex_y = buf_q[idx_q].y;
	assign vertices.tex_u = buf_q[idx_q].tex_u;
	assign vertices.tex_v = buf_q[idx_q].tex_v;
	assign vertices.tex_q = buf_q[idx_q].tex_q;
	assign vertices.vertex_index = idx_q;
	assign vertices.last = idx_q == LAST_IDX;
	assign vertices.degenerate = deg_q;

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && vertices.ready && idx_q != LAST_IDX |=> full_q)
		else $error("vertex run broke off before its fourth beat");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && vertices.ready && idx_q != LAST_IDX |=> idx_q == $past(idx_q) + 1'b1)
		else $error("vertex index did not advance by one");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!full_q |-> idx_q == qwvs_pkg::CORNER_TL)
		else $error("idle buffer holds a nonzero vertex index");

	a_degen_stable: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && idx_q != qwvs_pkg::CORNER_TL |-> $stable(deg_q))
		else $error("degenerate flag changed within a run");

endmodule

### src/quad_warp_vertex_setup.sv
// Takes one quadrilateral of four signed Q16.16 corners per input beat and returns four
// vertex beats (top-left, bottom-left, top-right, bottom-right) with projective texture
// coordinates. Quadrilaterals are accepted while the pipeline advances; it stalls only when a
// finished quadrilateral waits for the four-beat output buffer, which takes a new one when empty
// or as its last vertex beat leaves. Each input passes setup registers and then the 32-step
// pipelined divider that each of the four corner lanes carries. Configuration must be written while the block is idle.
module quad_warp_vertex_setup #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	qwvs_in_if.sink corners,
	qwvs_out_if.source vertices,
	qwvs_cfg_if.sink cfg
);

	localparam int LANE_LAT = qwvs_pkg::Q_W + 2;
	localparam int NC = qwvs_pkg::NUM_CORNERS;

	logic signed [qwvs_pkg::SRC_W-1:0] src_left_q;
	logic signed [qwvs_pkg::SRC_W-1:0] src_top_q;
	logic [qwvs_pkg::SRC_W-1:0] src_width_q;
	logic [qwvs_pkg::SRC_W-1:0] src_height_q;
	logic [qwvs_pkg::ROT_W-1:0] rot_mode_q;

	logic adv;
	logic can_load;

	logic signed [qwvs_pkg::COORD_W-1:0] sx_c [NC];
	logic signed [qwvs_pkg::COORD_W-1:0] sy_c [NC];
	logic signed [qwvs_pkg::COORD_W-1:0] x_c [NC];
	logic signed [qwvs_pkg::COORD_W-1:0] y_c [NC];

	logic v_s1, v_s2, v_s3;
	logic signed [qwvs_pkg::COORD_W-1:0] x_s1 [NC], y_s1 [NC];
	logic signed [qwvs_pkg::COORD_W-1:0] x_s2 [NC], y_s2 [NC];
	logic signed [qwvs_pkg::COORD_W-1:0] x_s3 [NC], y_s3 [NC];
	logic signed [qwvs_pkg::DIFF_W-1:0] rx_s1, ry_s1, qx_s1, qy_s1, cx_s1, cy_s1;
	logic signed [qwvs_pkg::PROD_W-1:0] p_rq_s2, p_rq2_s2, p_cq_s2, p_cq2_s2;
	logic signed [qwvs_pkg::PROD_W-1:0] p_cr_s2, p_cr2_s2;
	logic signed [qwvs_pkg::CROSS_W-1:0] d_s3, nt_s3, nu_s3;

	logic signed [qwvs_pkg::CROSS_W:0] dnt_c, dnu_c;
	logic [qwvs_pkg::MAG_W-1:0] own_c [NC];
	logic [qwvs_pkg::MAG_W-1:0] opp_c [NC];
	logic signed [qwvs_pkg::EDGE_W-1:0] eu_c [NC];
	logic signed [qwvs_pkg::EDGE_W-1:0] ev_c [NC];
	logic signed [qwvs_pkg::EDGE_W-1:0] left_e, right_e, top_e, bottom_e;
	logic dzero_c;
	logic [NC-1:0] bad_c;

	qwvs_pkg::lane_in_t lin_s4 [NC];
	logic any_s4;
	logic [LANE_LAT-1:0] vld_dly_q;
	logic [LANE_LAT-1:0] any_dly_q;
	qwvs_pkg::vertex_t lane_out [NC];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_left_q <= '0;
			src_top_q <= '0;
			src_width_q <= '0;
			src_height_q <= '0;
			rot_mode_q <= qwvs_pkg::ROT_SWAP;
		end else if (cfg.valid) begin
			case (cfg.index)
				qwvs_pkg::REG_SOURCE_LEFT: src_left_q <= cfg.data;
				qwvs_pkg::REG_SOURCE_TOP: src_top_q <= cfg.data;
				qwvs_pkg::REG_SOURCE_WIDTH: src_width_q <= cfg.data;
				qwvs_pkg::REG_SOURCE_HEIGHT: src_height_q <= cfg.data;
				qwvs_pkg::REG_ROTATION_MODE: rot_mode_q <= cfg.data[qwvs_pkg::ROT_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !vld_dly_q[LANE_LAT-1] || can_load;
	assign corners.ready = adv;

	assign sx_c[0] = corners.top_left_x;
	assign sy_c[0] = corners.top_left_y;
	assign sx_c[1] = corners.bottom_left_x;
	assign sy_c[1] = corners.bottom_left_y;
	assign sx_c[2] = corners.top_right_x;
	assign sy_c[2] = corners.top_right_y;
	assign sx_c[3] = corners.bottom_right_x;
	assign sy_c[3] = corners.bottom_right_y;

	always_comb begin
		x_c = sx_c;
		y_c = sy_c;
		case (rot_mode_q)
			qwvs_pkg::ROT_ROTATE: begin
				x_c[0] = sx_c[1]; y_c[0] = sy_c[1];
				x_c[1] = sx_c[3]; y_c[1] = sy_c[3];
				x_c[2] = sx_c[0]; y_c[2] = sy_c[0];
				x_c[3] = sx_c[2]; y_c[3] = sy_c[2];
			end
			qwvs_pkg::ROT_SWAP: begin
				x_c[1] = sx_c[2]; y_c[1] = sy_c[2];
				x_c[2] = sx_c[1]; y_c[2] = sy_c[1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vld_dly_q <= '0;
			any_dly_q <= '0;
		end else if (adv) begin
			v_s1 <= corners.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vld_dly_q <= {vld_dly_q[LANE_LAT-2:0], v_s3};
			any_dly_q <= {any_dly_q[LANE_LAT-2:0], any_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_c;
			y_s1 <= y_c;
			rx_s1 <= qwvs_pkg::DIFF_W'(x_c[3]) - qwvs_pkg::DIFF_W'(x_c[0]);
			ry_s1 <= qwvs_pkg::DIFF_W'(y_c[3]) - qwvs_pkg::DIFF_W'(y_c[0]);
			qx_s1 <= qwvs_pkg::DIFF_W'(x_c[1]) - qwvs_pkg::DIFF_W'(x_c[2]);
			qy_s1 <= qwvs_pkg::DIFF_W'(y_c[1]) - qwvs_pkg::DIFF_W'(y_c[2]);
			cx_s1 <= qwvs_pkg::DIFF_W'(x_c[2]) - qwvs_pkg::DIFF_W'(x_c[0]);
			cy_s1 <= qwvs_pkg::DIFF_W'(y_c[2]) - qwvs_pkg::DIFF_W'(y_c[0]);

			x_s2 <= x_s1;
			y_s2 <= y_s1;
			p_rq_s2 <= rx_s1 * qy_s1;
			p_rq2_s2 <= ry_s1 * qx_s1;
			p_cq_s2 <= cx_s1 * qy_s1;
			p_cq2_s2 <= cy_s1 * qx_s1;
			p_cr_s2 <= cx_s1 * ry_s1;
			p_cr2_s2 <= cy_s1 * rx_s1;

			x_s3 <= x_s2;
			y_s3 <= y_s2;
			d_s3 <= qwvs_pkg::CROSS_W'(p_rq_s2) - qwvs_pkg::CROSS_W'(p_rq2_s2);
			nt_s3 <= qwvs_pkg::CROSS_W'(p_cq_s2) - qwvs_pkg::CROSS_W'(p_cq2_s2);
			nu_s3 <= qwvs_pkg::CROSS_W'(p_cr_s2) - qwvs_pkg::CROSS_W'(p_cr2_s2);
		end
	end

	assign dnt_c = (qwvs_pkg::CROSS_W + 1)'(d_s3) - (qwvs_pkg::CROSS_W + 1)'(nt_s3);
	assign dnu_c = (qwvs_pkg::CROSS_W + 1)'(d_s3) - (qwvs_pkg::CROSS_W + 1)'(nu_s3);
	assign dzero_c = d_s3 == '0;

	assign own_c[0] = qwvs_pkg::abs_mag((qwvs_pkg::CROSS_W + 1)'(nt_s3));
	assign opp_c[0] = qwvs_pkg::abs_mag(dnt_c);
	assign own_c[3] = opp_c[0];
	assign opp_c[3] = own_c[0];
	assign own_c[2] = qwvs_pkg::abs_mag((qwvs_pkg::CROSS_W + 1)'(nu_s3));
	assign opp_c[2] = qwvs_pkg::abs_mag(dnu_c);
	assign own_c[1] = opp_c[2];
	assign opp_c[1] = own_c[2];

	assign left_e = qwvs_pkg::EDGE_W'(src_left_q);
	assign top_e = qwvs_pkg::EDGE_W'(src_top_q);
	assign right_e = left_e + $signed({2'b00, src_width_q});
	assign bottom_e = top_e + $signed({2'b00, src_height_q});

	assign eu_c[0] = left_e;
	assign eu_c[1] = left_e;
	assign eu_c[2] = right_e;
	assign eu_c[3] = right_e;
	assign ev_c[0] = top_e;
	assign ev_c[1] = bottom_e;
	assign ev_c[2] = top_e;
	assign ev_c[3] = bottom_e;

	for (genvar i = 0; i < NC; i++) begin : g_lane
		assign bad_c[i] = dzero_c || opp_c[i] == '0;
		assign lin_s4[i] = '{own: own_c[i], opp: opp_c[i], x: x_s3[i], y: y_s3[i],
			eu: eu_c[i], ev: ev_c[i], bad: bad_c[i]};

		qwvs_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.adv(adv),
			.lin(lin_s4[i]),
			.vout(lane_out[i])
		);
	end

	assign any_s4 = |bad_c;

	qwvs_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_dly_q[LANE_LAT-1]),
		.vin(lane_out),
		.in_degen(any_dly_q[LANE_LAT-1]),
		.can_load(can_load),
		.vertices(vertices)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef logic signed [qwvs_pkg::COORD_W-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic [qwvs_pkg::TEX_W-1:0] u;
		logic [qwvs_pkg::TEX_W-1:0] v;
		logic [qwvs_pkg::Q_W-1:0] q;
		logic [qwvs_pkg::IDX_W-1:0] idx;
		logic last;
		logic degen;
	} vertex_exp_t;

	typedef struct {
		coord_t c[8];
		bit typed;
	} quad_row_t;

	localparam logic [qwvs_pkg::Q_W-1:0] Q_SAT = '1;
	localparam logic signed [63:0] TEX_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] TEX_LO = -64'sh0000_8000_0000_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t ONE = 32'sh0001_0000;
	localparam logic [qwvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;

	qwvs_in_if corners ();
	qwvs_out_if vertices ();
	qwvs_cfg_if cfg ();

	quad_warp_vertex_setup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.corners(corners),
		.vertices(vertices),
		.cfg(cfg)
	);

	vertex_exp_t pending_vertices[$];
	int mismatches = 0;
	bit calm = 0;
	int ready_hold = 0;

	logic signed [63:0] src_left, src_top, src_width, src_height;
	logic [qwvs_pkg::ROT_W-1:0] rot_mode;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("testbench failed");
		$finish;
	end

	function automatic logic [127:0] magnitude(input logic signed [127:0] v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [qwvs_pkg::TEX_W-1:0] tex_of(input logic signed [63:0] edge_val,
		input logic [qwvs_pkg::Q_W-1:0] q, input bit bad);
		logic signed [63:0] p;
		if (bad) begin
			p = (edge_val > 0) ? TEX_HI : ((edge_val < 0) ? TEX_LO : 64'sd0);
		end else begin
			p = edge_val * $signed({32'd0, q});
			if (p > TEX_HI) p = TEX_HI;
			if (p < TEX_LO) p = TEX_LO;
		end
		return p[qwvs_pkg::TEX_W-1:0];
	endfunction

	function automatic void predict_vertices(input coord_t c[8]);
		int sel[4];
		logic signed [127:0] x[4], y[4];
		logic signed [127:0] rx, ry, qx, qy, cx, cy, d, nt, nu;
		logic [127:0] own[4], opp[4], num, quo;
		logic signed [63:0] eu[4], ev[4];
		bit bad[4];
		bit any;
		vertex_exp_t e;
		sel = '{0, 1, 2, 3};
		if (rot_mode == qwvs_pkg::ROT_ROTATE) sel = '{1, 3, 0, 2};
		else if (rot_mode == qwvs_pkg::ROT_SWAP) sel = '{0, 2, 1, 3};
		for (int i = 0; i < 4; i++) begin
			x[i] = c[2 * sel[i]];
			y[i] = c[2 * sel[i] + 1];
		end
		rx = x[3] - x[0];
		ry = y[3] - y[0];
		qx = x[1] - x[2];
		qy = y[1] - y[2];
		cx = x[2] - x[0];
		cy = y[2] - y[0];
		d = rx * qy - ry * qx;
		nt = cx * qy - cy * qx;
		nu = cx * ry - cy * rx;
		own[0] = magnitude(nt);
		opp[0] = magnitude(d - nt);
		own[3] = opp[0];
		opp[3] = own[0];
		own[2] = magnitude(nu);
		opp[2] = magnitude(d - nu);
		own[1] = opp[2];
		opp[1] = own[2];
		eu[0] = src_left;
		eu[1] = src_left;
		eu[2] = src_left + src_width;
		eu[3] = eu[2];
		ev[0] = src_top;
		ev[2] = src_top;
		ev[1] = src_top + src_height;
		ev[3] = ev[1];
		any = 0;
		for (int i = 0; i < 4; i++) begin
			bad[i] = (d == 0) || (opp[i] == 0);
			any |= bad[i];
		end
		for (int i = 0; i < 4; i++) begin
			if (bad[i]) begin
				e.q = Q_SAT;
			end else begin
				num = ((own[i] + opp[i]) << 16) + opp[i];
				quo = num / (opp[i] << 1);
				e.q = (quo > 128'hFFFF_FFFF) ? Q_SAT : quo[qwvs_pkg::Q_W-1:0];
			end
			e.x = x[i][31:0];
			e.y = y[i][31:0];
			e.u = tex_of(eu[i], e.q, bad[i]);
			e.v = tex_of(ev[i], e.q, bad[i]);
			e.idx = qwvs_pkg::IDX_W'(i);
			e.last = (i == 3);
			e.degen = any;
			pending_vertices = {pending_vertices, e};
		end
	endfunction

	// Coincident corners: every corner degenerate, tex expected zero as the source edges are zero.
	function automatic void expect_coincident(input coord_t c[8]);
		vertex_exp_t e;
		for (int i = 0; i < 4; i++) begin
			e.x = c[0];
			e.y = c[1];
			e.q = Q_SAT;
			e.u = '0;
			e.v = '0;
			e.idx = qwvs_pkg::IDX_W'(i);
			e.last = (i == 3);
			e.degen = 1;
			pending_vertices = {pending_vertices, e};
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n || calm) begin
			vertices.ready <= !calm ? 1'b0 : 1'b1;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			vertices.ready <= 0;
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			vertices.ready <= 0;
			ready_hold <= $urandom_range(0, 14);
		end else begin
			vertices.ready <= 1;
		end
	end

	always @(posedge clk) begin
		vertex_exp_t e;
		if (arst_n && vertices.valid && vertices.ready) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex beat, index %0d",
					vertices.vertex_index);
			end else begin
				e = pending_vertices.pop_front();
				if (vertices.vertex_x !== e.x || vertices.vertex_y !== e.y ||
					vertices.tex_u !== e.u || vertices.tex_v !== e.v ||
					vertices.tex_q !== e.q || vertices.vertex_index !== e.idx ||
					vertices.last !== e.last || vertices.degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("vertex mismatch, expected x %h y %h u %h v %h q %h i %0d l %b g %b",
							e.x, e.y, e.u, e.v, e.q, e.idx, e.last, e.degen);
						$display("                  actual x %h y %h u %h v %h q %h i %0d l %b g %b",
							vertices.vertex_x, vertices.vertex_y, vertices.tex_u,
							vertices.tex_v, vertices.tex_q, vertices.vertex_index,
							vertices.last, vertices.degenerate);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [qwvs_pkg::CFG_IDX_W-1:0] index, input int value);
		cfg.valid <= 1;
		cfg.index <= index;
		cfg.data <= value[qwvs_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (index)
			qwvs_pkg::REG_SOURCE_LEFT: src_left = $signed(value[15:0]);
			qwvs_pkg::REG_SOURCE_TOP: src_top = $signed(value[15:0]);
			qwvs_pkg::REG_SOURCE_WIDTH: src_width = value[15:0];
			qwvs_pkg::REG_SOURCE_HEIGHT: src_height = value[15:0];
			qwvs_pkg::REG_ROTATION_MODE: rot_mode = value[qwvs_pkg::ROT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_quad(input coord_t c[8], input bit typed);
		if (!calm && $urandom_range(0, 4) == 0) begin
			corners.valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		corners.valid <= 1;
		corners.top_left_x <= c[0];
		corners.top_left_y <= c[1];
		corners.bottom_left_x <= c[2];
		corners.bottom_left_y <= c[3];
		corners.top_right_x <= c[4];
		corners.top_right_y <= c[5];
		corners.bottom_right_x <= c[6];
		corners.bottom_right_y <= c[7];
		@(posedge clk);
		while (!corners.ready) @(posedge clk);
		if (typed) expect_coincident(c);
		else predict_vertices(c);
	endtask

	function automatic void random_quad(output coord_t c[8]);
		int kind;
		coord_t ox, oy, w, h;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			ox = $urandom_range(0, 4000) * ONE - 2000 * ONE + $urandom_range(0, 65535);
			oy = $urandom_range(0, 4000) * ONE - 2000 * ONE + $urandom_range(0, 65535);
			w = $urandom_range(1, 3000) * ONE + $urandom_range(0, 65535);
			h = $urandom_range(1, 3000) * ONE + $urandom_range(0, 65535);
			c[0] = ox;
			c[1] = oy;
			c[2] = ox;
			c[3] = oy + h;
			c[4] = ox + w;
			c[5] = oy;
			c[6] = ox + w;
			c[7] = oy + h;
			foreach (c[k]) c[k] = c[k] + $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
		end else if (kind == 7) begin
			c[0] = $urandom;
			c[1] = $urandom;
			for (int k = 2; k < 8; k += 2) begin
				c[k] = c[0] + $signed($urandom_range(0, 8)) * ONE;
				c[k + 1] = c[1] + (c[k] - c[0]);
			end
		end else begin
			foreach (c[k]) c[k] = $urandom;
		end
	endfunction

	quad_row_t rows[] = '{
		'{'{0, 0, 0, ONE, ONE, 0, ONE, ONE}, 0},
		'{'{0, 0, 0, 0, 0, 0, 0, 0}, 1},
		'{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1},
		'{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1},
		'{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX}, 0},
		'{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN}, 0},
		'{'{0, 0, ONE, ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE}, 0},
		'{'{0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0}, 0},
		'{'{0, 0, 0, 4 * ONE, ONE, 0, 3 * ONE, 4 * ONE}, 0},
		'{'{0, 0, -ONE, 3 * ONE, 5 * ONE, ONE, 4 * ONE, 7 * ONE}, 0},
		'{'{1, 2, 3, 5, 7, 1, 9, 8}, 0},
		'{'{C_MIN, 0, 0, C_MAX, C_MAX, 0, 0, C_MIN}, 0}
	};

	int settings[5][5] = '{
		'{0, 0, 640, 480, 0},
		'{-32768, -32768, 65535, 65535, 1},
		'{32767, 32767, 65535, 65535, 2},
		'{-100, 50, 0, 0, 3},
		'{123, -7, 1920, 1080, 1}
	};

	initial begin
		coord_t c[8];
		arst_n = 0;
		corners.valid = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		vertices.ready = 0;
		corners.top_left_x = 0;
		corners.top_left_y = 0;
		corners.bottom_left_x = 0;
		corners.bottom_left_y = 0;
		corners.top_right_x = 0;
		corners.top_right_y = 0;
		corners.bottom_right_x = 0;
		corners.bottom_right_y = 0;
		src_left = 0;
		src_top = 0;
		src_width = 0;
		src_height = 0;
		rot_mode = qwvs_pkg::ROT_SWAP;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (60) @(posedge clk);

		foreach (rows[r]) send_quad(rows[r].c, rows[r].typed);
		corners.valid <= 0;

		for (int p = 0; p < 5; p++) begin
			drain();
			write_reg(qwvs_pkg::REG_SOURCE_LEFT, settings[p][0]);
			write_reg(qwvs_pkg::REG_SOURCE_TOP, settings[p][1]);
			write_reg(qwvs_pkg::REG_SOURCE_WIDTH, settings[p][2]);
			write_reg(qwvs_pkg::REG_SOURCE_HEIGHT, settings[p][3]);
			write_reg(qwvs_pkg::REG_ROTATION_MODE, settings[p][4]);
			if (p == 0) write_reg(REG_UNUSED, 16'hFFFF);
			cfg.valid <= 0;
			calm = (p == 4);
			for (int n = 0; n < 40; n++) begin
				random_quad(c);
				send_quad(c, 0);
				if (p == 2 && n == 20) begin
					corners.valid <= 0;
					while (pending_vertices.size() != 0) @(posedge clk);
				end
			end
			corners.valid <= 0;
		end

		drain();
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

### sim.f
src/qwvs_pkg.sv
src/qwvs_in_if.sv
src/qwvs_out_if.sv
src/qwvs_cfg_if.sv
src/qwvs_lane.sv
src/qwvs_merge.sv
src/quad_warp_vertex_setup.sv
tb/sv/testbench.sv
